// ===== rtl/core/cot_pkg.sv =====
// Shared constants for the capsule overlap test block.
`timescale 1ns / 1ps

package cot_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int POINT_W        = 48;
    localparam int RADIUS_W       = 16;
    localparam int DATA_W         = 224;
    localparam int OUT_DATA_W     = 8;
    localparam int NUM_LANES      = 6;
    localparam int NUM_STAGES     = 7;

    // tdata field offsets
    localparam int FS_LSB = 0;
    localparam int FE_LSB = 48;
    localparam int FR_LSB = 96;
    localparam int SS_LSB = 112;
    localparam int SE_LSB = 160;
    localparam int SR_LSB = 208;

    // command codes
    localparam logic CMD_CAPSULE = 1'b0;
    localparam logic CMD_SPHERE  = 1'b1;

    // lane that tests the second start against the first segment
    localparam int SPHERE_LANE = 2;

endpackage

// ===== rtl/core/capsule_overlap_test.sv =====
// Capsule overlap test: seven-stage pipeline, six point-to-segment lanes.
`timescale 1ns / 1ps
// Each item passes through seven registers, the input register included.
// Throughput: one item per cycle while the sink accepts;
// each lane works on its own point and segment.
// The pipeline collapses bubbles: a stage moves when its successor is empty or moving.
// The output register holds a result while the sink stalls; input keeps filling
// earlier stages until they are all full.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.

module capsule_overlap_test #(
    parameter int COORD_BITS = cot_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: first_start[47:0], first_end[95:48], first_radius[111:96],
    //        second_start[159:112], second_end[207:160], second_radius[223:208]
    input  logic [cot_pkg::DATA_W-1:0]      i_s_axis_tdata,
    // tuser: command[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: hit[0], zero fill above
    output logic [cot_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import cot_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int PW  = C + 1;          // doubled point / midpoint
    localparam int DW  = C + 2;          // point differences
    localparam int P   = 2 * DW + 2;     // sums of squares
    localparam int RSW = RADIUS_W + 2;   // doubled radius sum
    localparam int R2W = 2 * RSW;
    localparam int MW  = (P > R2W) ? P : R2W;
    localparam int H   = (MW + 1) / 2;   // low half of a split operand
    localparam int L   = NUM_LANES;

    // Handshake and stage movement
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: input register
    logic              r_cmd0;
    logic [DATA_W-1:0] r_dat0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cmd0 <= i_s_axis_tuser;
            r_dat0 <= i_s_axis_tdata;
        end
    end

    // Stage 1: unpack, doubled points and midpoints, per-lane differences
    // points are zero-extended so bits above the 48-bit field read as zero
    function automatic logic signed [PW-1:0] dbl_pt(input logic [POINT_W-1:0] pk,
                                                    input int ax);
        logic [2*POINT_W-1:0] px;
        logic [C-1:0] c;
        begin
            px = (2*POINT_W)'(pk);
            c = px[ax*C +: C];
            return $signed({c, 1'b0});
        end
    endfunction

    function automatic logic signed [PW-1:0] mid_pt(input logic [POINT_W-1:0] pa,
                                                    input logic [POINT_W-1:0] pb,
                                                    input int ax);
        logic [2*POINT_W-1:0] pxa;
        logic [2*POINT_W-1:0] pxb;
        logic [C-1:0] ca;
        logic [C-1:0] cb;
        begin
            pxa = (2*POINT_W)'(pa);
            pxb = (2*POINT_W)'(pb);
            ca = pxa[ax*C +: C];
            cb = pxb[ax*C +: C];
            return $signed({ca[C-1], ca}) + $signed({cb[C-1], cb});
        end
    endfunction

    logic                  r_cmd1;
    logic [RSW-1:0]        r_rs1;
    logic signed [DW-1:0]  r_w1 [L][3];
    logic signed [DW-1:0]  r_d1 [L][3];
    logic signed [DW-1:0]  r_e1 [L][3];
    logic signed [DW-1:0]  n_w1 [L][3];
    logic signed [DW-1:0]  n_d1 [L][3];
    logic signed [DW-1:0]  n_e1 [L][3];
    logic [RSW-1:0]        n_rs1;

    always_comb begin
        logic [POINT_W-1:0]   fs, fe, ss, se;
        logic signed [PW-1:0] a1, b1, a2, b2, m1, m2;
        logic signed [PW-1:0] pp [L];
        logic signed [PW-1:0] sa [L];
        logic signed [PW-1:0] sb [L];
        fs = r_dat0[FS_LSB +: POINT_W];
        fe = r_dat0[FE_LSB +: POINT_W];
        ss = r_dat0[SS_LSB +: POINT_W];
        se = r_dat0[SE_LSB +: POINT_W];
        n_rs1 = {(RSW-1)'({1'b0, r_dat0[FR_LSB +: RADIUS_W]})
                 + (RSW-1)'({1'b0, r_dat0[SR_LSB +: RADIUS_W]}), 1'b0};
        for (int ax = 0; ax < 3; ax++) begin
            a1 = dbl_pt(fs, ax);
            b1 = dbl_pt(fe, ax);
            a2 = dbl_pt(ss, ax);
            b2 = dbl_pt(se, ax);
            m1 = mid_pt(fs, fe, ax);
            m2 = mid_pt(ss, se, ax);
            // lane order: a1, b1 vs seg2; a2, b2 vs seg1; m1 vs seg2; m2 vs seg1
            pp[0] = a1; sa[0] = a2; sb[0] = b2;
            pp[1] = b1; sa[1] = a2; sb[1] = b2;
            pp[2] = a2; sa[2] = a1; sb[2] = b1;
            pp[3] = b2; sa[3] = a1; sb[3] = b1;
            pp[4] = m1; sa[4] = a2; sb[4] = b2;
            pp[5] = m2; sa[5] = a1; sb[5] = b1;
            for (int ln = 0; ln < L; ln++) begin
                n_w1[ln][ax] = DW'(pp[ln]) - DW'(sa[ln]);
                n_d1[ln][ax] = DW'(sb[ln]) - DW'(sa[ln]);
                n_e1[ln][ax] = DW'(pp[ln]) - DW'(sb[ln]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cmd1 <= r_cmd0;
            r_rs1  <= n_rs1;
            r_w1   <= n_w1;
            r_d1   <= n_d1;
            r_e1   <= n_e1;
        end
    end

    // Stage 2: dot products and squared radius sum
    logic                 r_cmd2;
    logic [R2W-1:0]       r_r2_2;
    logic [P-1:0]         r_ww2 [L];
    logic [P-1:0]         r_ll2 [L];
    logic [P-1:0]         r_ee2 [L];
    logic signed [P:0]    r_t2  [L];
    logic [P-1:0]         n_ww2 [L];
    logic [P-1:0]         n_ll2 [L];
    logic [P-1:0]         n_ee2 [L];
    logic signed [P:0]    n_t2  [L];

    always_comb begin
        logic signed [P:0] aw, al, ae, at;
        for (int ln = 0; ln < L; ln++) begin
            aw = '0;
            al = '0;
            ae = '0;
            at = '0;
            for (int ax = 0; ax < 3; ax++) begin
                aw = aw + r_w1[ln][ax] * r_w1[ln][ax];
                al = al + r_d1[ln][ax] * r_d1[ln][ax];
                ae = ae + r_e1[ln][ax] * r_e1[ln][ax];
                at = at + r_w1[ln][ax] * r_d1[ln][ax];
            end
            n_ww2[ln] = aw[P-1:0];
            n_ll2[ln] = al[P-1:0];
            n_ee2[ln] = ae[P-1:0];
            n_t2[ln]  = at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_cmd2 <= r_cmd1;
            r_r2_2 <= r_rs1 * r_rs1;
            r_ww2  <= n_ww2;
            r_ll2  <= n_ll2;
            r_ee2  <= n_ee2;
            r_t2   <= n_t2;
        end
    end

    // Stage 3: region flags, near-endpoint compares, split partial products
    // products: 0 = ww*L2, 1 = t*t, 2 = r2*L2
    logic             r_cmd3;
    logic [L-1:0]     r_lo3, r_hi3, r_ns3, r_ne3;
    logic [2*H-1:0]   r_pll3 [L][3];
    logic [2*H-1:0]   r_plh3 [L][3];
    logic [2*H-1:0]   r_phl3 [L][3];
    logic [2*H-1:0]   r_phh3 [L][3];
    logic [L-1:0]     n_lo3, n_hi3, n_ns3, n_ne3;
    logic [2*H-1:0]   n_pll3 [L][3];
    logic [2*H-1:0]   n_plh3 [L][3];
    logic [2*H-1:0]   n_phl3 [L][3];
    logic [2*H-1:0]   n_phh3 [L][3];

    always_comb begin
        logic [MW-1:0] opa [3];
        logic [MW-1:0] opb [3];
        logic [MW-1:0] r2x;
        r2x = MW'(r_r2_2);
        for (int ln = 0; ln < L; ln++) begin
            n_lo3[ln] = (r_t2[ln] <= 0);
            n_hi3[ln] = !n_lo3[ln] && (r_t2[ln] >= $signed({1'b0, r_ll2[ln]}));
            n_ns3[ln] = (MW'(r_ww2[ln]) <= r2x);
            n_ne3[ln] = (MW'(r_ee2[ln]) <= r2x);
            opa[0] = MW'(r_ww2[ln]);
            opb[0] = MW'(r_ll2[ln]);
            opa[1] = MW'(r_t2[ln][P-1:0]);
            opb[1] = MW'(r_t2[ln][P-1:0]);
            opa[2] = r2x;
            opb[2] = MW'(r_ll2[ln]);
            for (int pr = 0; pr < 3; pr++) begin
                n_pll3[ln][pr] = (2*H)'(opa[pr][H-1:0] * opb[pr][H-1:0]);
                n_plh3[ln][pr] = (2*H)'(opa[pr][H-1:0] * opb[pr][MW-1:H]);
                n_phl3[ln][pr] = (2*H)'(opa[pr][MW-1:H] * opb[pr][H-1:0]);
                n_phh3[ln][pr] = (2*H)'(opa[pr][MW-1:H] * opb[pr][MW-1:H]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_cmd3 <= r_cmd2;
            r_lo3  <= n_lo3;
            r_hi3  <= n_hi3;
            r_ns3  <= n_ns3;
            r_ne3  <= n_ne3;
            r_pll3 <= n_pll3;
            r_plh3 <= n_plh3;
            r_phl3 <= n_phl3;
            r_phh3 <= n_phh3;
        end
    end

    // Stage 4: assemble full products
    logic              r_cmd4;
    logic [L-1:0]      r_lo4, r_hi4, r_ns4, r_ne4;
    logic [2*MW-1:0]   r_prod4 [L][3];
    logic [2*MW-1:0]   n_prod4 [L][3];

    always_comb begin
        for (int ln = 0; ln < L; ln++) begin
            for (int pr = 0; pr < 3; pr++) begin
                n_prod4[ln][pr] = (2*MW)'(r_pll3[ln][pr])
                    + (((2*MW)'(r_plh3[ln][pr]) + (2*MW)'(r_phl3[ln][pr])) << H)
                    + ((2*MW)'(r_phh3[ln][pr]) << (2*H));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_cmd4  <= r_cmd3;
            r_lo4   <= r_lo3;
            r_hi4   <= r_hi3;
            r_ns4   <= r_ns3;
            r_ne4   <= r_ne3;
            r_prod4 <= n_prod4;
        end
    end

    // Stage 5: per-lane decision
    // projected case: ww*L2 - t*t <= r2*L2, rewritten without subtraction
    logic          r_cmd5;
    logic [L-1:0]  r_hit5;
    logic [L-1:0]  n_hit5;

    always_comb begin
        logic proj;
        for (int ln = 0; ln < L; ln++) begin
            proj = ({1'b0, r_prod4[ln][0]})
                   <= ({1'b0, r_prod4[ln][2]} + {1'b0, r_prod4[ln][1]});
            if (r_lo4[ln]) begin
                n_hit5[ln] = r_ns4[ln];
            end else if (r_hi4[ln]) begin
                n_hit5[ln] = r_ne4[ln];
            end else begin
                n_hit5[ln] = proj;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_cmd5 <= r_cmd4;
            r_hit5 <= n_hit5;
        end
    end

    // Stage 6: combine lanes by mode, output register
    logic r_hit6;
    logic n_hit6;

    always_comb begin
        case (r_cmd5)
            CMD_SPHERE:  n_hit6 = r_hit5[SPHERE_LANE];
            CMD_CAPSULE: n_hit6 = |r_hit5;
            default:     n_hit6 = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_hit6 <= n_hit6;
        end
    end

    assign o_m_axis_tvalid = r_v[NUM_STAGES-1];
    assign o_m_axis_tdata  = {(OUT_DATA_W-1)'(0), r_hit6};

    // Assertions
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NUM_STAGES-1] |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> ((r_lo4 & r_hi4) == '0))
        else $error("lane flagged both before start and past end");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && en[6]) |=> r_v[6])
        else $error("item lost between decision and output stage");

    a_cauchy_l0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !r_lo4[0]) |-> (r_prod4[0][1] <= r_prod4[0][0]))
        else $error("lane 0 projection exceeds length product");

    a_cauchy_l2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !r_lo4[SPHERE_LANE])
            |-> (r_prod4[SPHERE_LANE][1] <= r_prod4[SPHERE_LANE][0]))
        else $error("sphere lane projection exceeds length product");

endmodule
